@@ src/chunk_range_set_queue_core_macros.svh @@
// Assertion macros for the chunk range set queue.
// No dependencies.
`ifndef CHUNK_RANGE_SET_QUEUE_CORE_MACROS_SVH
`define CHUNK_RANGE_SET_QUEUE_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CRSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Invariant checked on every rising clock edge outside reset.
`define CRSQ_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`endif

@@ src/crsq_pkg.sv @@
// Package for the chunk range set queue: constants, state and cell types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package crsq_pkg;
	localparam int MaxRangesDefault = 16;
	localparam int ChunkBitsDefault = 32;
	localparam int FieldBits = 32;

	localparam logic FuncInsert = 1'b0;
	localparam logic FuncGet = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_SCAN,
		ST_INS_APPLY,
		ST_MERGE,
		ST_GET,
		ST_DONE
	} state_t;

	// Operation broadcast to every cell.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_OPEN,
		CELL_CLOSE,
		CELL_WRITE,
		CELL_FOLD
	} cell_op_t;
endpackage
`default_nettype wire

@@ src/chunk_range_set_queue_core.sv @@
// Chunk range set queue: sequencer over a chain of range cells.
// Depends on crsq_pkg, crsq_cell and chunk_range_set_queue_core_macros.svh.
//
//  channel | signals                                  | handshake
//  input   | func, first_chunk, chunk_count           | start && !busy
//  result  | chunk, chunk_valid, present, table_full  | done strobe, one cycle
//
// An insert scans back one entry a cycle, then opens a gap, updates an entry
// or flags a full table, then, if it grew to the left, merges one left neighbor
// a cycle. A get passes through the get and done states. The next item is taken
// at the edge that ends the result strobe. Shifts move all cells at or above the
// target together. Reset clears counts and cursor; cell contents are undefined
// until written. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "chunk_range_set_queue_core_macros.svh"
module chunk_range_set_queue_core #(
	parameter int MAX_RANGES = crsq_pkg::MaxRangesDefault,
	parameter int CHUNK_BITS = crsq_pkg::ChunkBitsDefault
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            func,
	input  wire logic [crsq_pkg::FieldBits-1:0]  first_chunk,
	input  wire logic [crsq_pkg::FieldBits-1:0]  chunk_count,
	output logic                                 done,
	output logic      [crsq_pkg::FieldBits-1:0]  chunk,
	output logic                                 chunk_valid,
	output logic                                 present,
	output logic                                 table_full
);
	localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int FB = crsq_pkg::FieldBits;
	localparam logic [CW-1:0] MaxCount = CW'(MAX_RANGES);

	typedef logic [CHUNK_BITS-1:0] val_t;

	crsq_pkg::state_t state_q, state_d;
	logic [CW-1:0] used_q;
	logic [IW-1:0] cur_q;
	logic          cur_set_q;
	// Scan pointer: p+1 so zero means "before first entry".
	logic [CW-1:0] p1_q;
	val_t          first_q, count_q, right_q;
	logic          func_q;
	logic [FB-1:0] chunk_q;
	logic          valid_q, full_q, done_q;

	val_t start_arr [MAX_RANGES];
	val_t len_arr   [MAX_RANGES];

	crsq_pkg::cell_op_t op;
	logic [IW-1:0] tgt;
	val_t          w_start, w_len;

	// Serial-number compares.
	function automatic logic ser_after(input val_t a, input val_t b);
		val_t d;
		d = a - b;
		return (d != '0) && !d[CHUNK_BITS-1];
	endfunction

	function automatic logic ser_before(input val_t a, input val_t b);
		val_t d;
		d = a - b;
		return d[CHUNK_BITS-1];
	endfunction

	// Entry under the scan pointer and its left neighbor.
	logic [IW-1:0] pi, qi;
	val_t p_start, p_len, p_end, q_start, q_end;
	assign pi      = IW'(p1_q - CW'(1));
	assign qi      = IW'(p1_q - CW'(2));
	assign p_start = start_arr[pi];
	assign p_len   = len_arr[pi];
	assign p_end   = p_start + p_len;
	assign q_start = start_arr[qi];
	assign q_end   = q_start + len_arr[qi];

	// Range that results from folding p into its left neighbor q.
	val_t m_start, m_len;
	assign m_start = q_start;
	assign m_len   = p_end - q_start;

	logic [IW-1:0] gi;
	val_t g_start, g_len;
	assign gi      = cur_set_q ? cur_q : '0;
	assign g_start = start_arr[gi];
	assign g_len   = len_arr[gi];

	// Build the cell chain.
	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		val_t ls, ll, rs, rl;
		if (i == 0) begin : g_l0
			assign ls = '0;
			assign ll = '0;
		end else begin : g_ln
			assign ls = start_arr[i-1];
			assign ll = len_arr[i-1];
		end
		if (i == MAX_RANGES - 1) begin : g_rl
			assign rs = '0;
			assign rl = '0;
		end else begin : g_rn
			assign rs = start_arr[i+1];
			assign rl = len_arr[i+1];
		end
		crsq_cell #(.CHUNK_BITS(CHUNK_BITS)) u_cell (
			.clk        (clk),
			.op         (op),
			.at_or_above(IW'(i) >= tgt),
			.at_target  (IW'(i) == tgt),
			.left_start (ls),
			.left_len   (ll),
			.right_start(rs),
			.right_len  (rl),
			.new_start  (w_start),
			.new_len    (w_len),
			.start_q    (start_arr[i]),
			.len_q      (len_arr[i])
		);
	end

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != crsq_pkg::ST_IDLE);

	// Scan decision signals.
	logic scan_stop, need_new, do_merge;
	assign scan_stop = (p1_q == '0) || !ser_before(right_q, p_start);
	assign need_new  = (p1_q == '0) || ser_after(first_q, p_end);
	assign do_merge  = (p1_q > CW'(1)) && !ser_before(q_end, p_start);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			crsq_pkg::ST_IDLE: begin
				if (accept) begin
					if (func == crsq_pkg::FuncGet)
						state_d = crsq_pkg::ST_GET;
					else if (CHUNK_BITS'(chunk_count) == val_t'(0))
						state_d = crsq_pkg::ST_DONE;
					else
						state_d = crsq_pkg::ST_INS_SCAN;
				end
			end
			crsq_pkg::ST_INS_SCAN: begin
				if (scan_stop) state_d = crsq_pkg::ST_INS_APPLY;
			end
			crsq_pkg::ST_INS_APPLY: begin
				if (need_new || !ser_before(first_q, p_start))
					state_d = crsq_pkg::ST_DONE;
				else
					state_d = crsq_pkg::ST_MERGE;
			end
			crsq_pkg::ST_MERGE: begin
				if (!do_merge) state_d = crsq_pkg::ST_DONE;
			end
			crsq_pkg::ST_GET:  state_d = crsq_pkg::ST_DONE;
			crsq_pkg::ST_DONE: state_d = crsq_pkg::ST_IDLE;
			default:           state_d = crsq_pkg::ST_IDLE;
		endcase
	end

	// Cell operation of this cycle.
	always_comb begin
		val_t ext_len, ne;
		op      = crsq_pkg::CELL_HOLD;
		tgt     = pi;
		w_start = first_q;
		w_len   = count_q;
		ext_len = ser_after(right_q, p_end) ? (right_q - p_start) : p_len;
		ne      = p_start + ext_len;
		case (state_q)
			crsq_pkg::ST_INS_APPLY: begin
				if (need_new) begin
					if (used_q < MaxCount) begin
						op  = crsq_pkg::CELL_OPEN;
						tgt = IW'(p1_q);
					end
				end else if (ser_before(first_q, p_start)) begin
					op      = crsq_pkg::CELL_WRITE;
					w_start = first_q;
					w_len   = ne - first_q;
				end else begin
					op      = crsq_pkg::CELL_WRITE;
					w_start = p_start;
					w_len   = ext_len;
				end
			end
			crsq_pkg::ST_MERGE: begin
				if (do_merge) begin
					// Fold p into its left neighbor q, then close the gap above q.
					op      = crsq_pkg::CELL_FOLD;
					tgt     = qi;
					w_start = m_start;
					w_len   = m_len;
				end
			end
			crsq_pkg::ST_GET: begin
				if (cur_set_q || used_q != '0) begin
					tgt = gi;
					if (g_len > val_t'(1)) begin
						op      = crsq_pkg::CELL_WRITE;
						w_start = g_start + val_t'(1);
						w_len   = g_len - val_t'(1);
					end else begin
						op = crsq_pkg::CELL_CLOSE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= crsq_pkg::ST_IDLE;
			used_q    <= '0;
			cur_q     <= '0;
			cur_set_q <= 1'b0;
			p1_q      <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == crsq_pkg::ST_DONE);
			case (state_q)
				crsq_pkg::ST_IDLE: begin
					if (accept) p1_q <= used_q;
				end
				crsq_pkg::ST_INS_SCAN: begin
					if (!scan_stop) p1_q <= p1_q - CW'(1);
				end
				crsq_pkg::ST_INS_APPLY: begin
					if (need_new && used_q < MaxCount) begin
						used_q <= used_q + CW'(1);
						if (cur_set_q && CW'(cur_q) >= p1_q) cur_q <= cur_q + IW'(1);
					end
				end
				crsq_pkg::ST_MERGE: begin
					if (do_merge) begin
						used_q <= used_q - CW'(1);
						p1_q   <= p1_q - CW'(1);
						if (cur_set_q) begin
							if (cur_q == qi) begin
								if (CW'(qi) + CW'(1) >= used_q) begin
									cur_set_q <= 1'b0;
									cur_q     <= '0;
								end
							end else if (cur_q > qi) begin
								cur_q <= cur_q - IW'(1);
							end
						end
					end
				end
				crsq_pkg::ST_GET: begin
					if (cur_set_q || used_q != '0) begin
						if (g_len <= val_t'(1)) begin
							used_q <= used_q - CW'(1);
							// Drop the cursor when the last range empties.
							if (CW'(gi) + CW'(1) >= used_q) begin
								cur_set_q <= 1'b0;
								cur_q     <= '0;
							end else begin
								cur_set_q <= 1'b1;
								cur_q     <= gi;
							end
						end else begin
							cur_set_q <= 1'b1;
							cur_q     <= gi;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			first_q <= CHUNK_BITS'(first_chunk);
			count_q <= CHUNK_BITS'(chunk_count);
			right_q <= CHUNK_BITS'(first_chunk) + CHUNK_BITS'(chunk_count);
			chunk_q <= '0;
			valid_q <= 1'b0;
			full_q  <= 1'b0;
		end
		if (state_q == crsq_pkg::ST_INS_APPLY && need_new && used_q >= MaxCount)
			full_q <= 1'b1;
		if (state_q == crsq_pkg::ST_GET && (cur_set_q || used_q != '0)) begin
			chunk_q <= FB'(g_start);
			valid_q <= 1'b1;
		end
	end

	assign done        = done_q;
	assign chunk       = chunk_q;
	assign chunk_valid = valid_q;
	assign table_full  = full_q;
	assign present     = (used_q != '0) && (len_arr[0] != '0);

	`CRSQ_ASSERT_ALWAYS(a_used_range, clk, arst_n, used_q <= MaxCount)
	`CRSQ_ASSERT_IMPL(a_cur_in_table, clk, arst_n, cur_set_q, CW'(cur_q) < used_q)
	`CRSQ_ASSERT_IMPL(a_done_idle, clk, arst_n, done, state_q == crsq_pkg::ST_IDLE)
	`CRSQ_ASSERT_IMPL(a_valid_get, clk, arst_n, done && chunk_valid,
		func_q == crsq_pkg::FuncGet)
endmodule
`default_nettype wire

@@ src/crsq_cell.sv @@
// One table cell: holds a range start and length, shifts with its neighbors.
// Depends on crsq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module crsq_cell #(
	parameter int CHUNK_BITS = crsq_pkg::ChunkBitsDefault
) (
	input  wire logic                  clk,
	input  wire crsq_pkg::cell_op_t    op,
	input  wire logic                  at_or_above,
	input  wire logic                  at_target,
	input  wire logic [CHUNK_BITS-1:0] left_start,
	input  wire logic [CHUNK_BITS-1:0] left_len,
	input  wire logic [CHUNK_BITS-1:0] right_start,
	input  wire logic [CHUNK_BITS-1:0] right_len,
	input  wire logic [CHUNK_BITS-1:0] new_start,
	input  wire logic [CHUNK_BITS-1:0] new_len,
	output logic      [CHUNK_BITS-1:0] start_q,
	output logic      [CHUNK_BITS-1:0] len_q
);
	// Shift up (open a gap), shift down (close a gap), or write in place.
	always_ff @(posedge clk) begin
		case (op)
			crsq_pkg::CELL_OPEN: begin
				if (at_target) begin
					start_q <= new_start;
					len_q   <= new_len;
				end else if (at_or_above) begin
					start_q <= left_start;
					len_q   <= left_len;
				end
			end
			crsq_pkg::CELL_CLOSE: begin
				if (at_or_above) begin
					start_q <= right_start;
					len_q   <= right_len;
				end
			end
			crsq_pkg::CELL_WRITE: begin
				if (at_target) begin
					start_q <= new_start;
					len_q   <= new_len;
				end
			end
			// Write the merged range at the target and close the gap above it.
			crsq_pkg::CELL_FOLD: begin
				if (at_target) begin
					start_q <= new_start;
					len_q   <= new_len;
				end else if (at_or_above) begin
					start_q <= right_start;
					len_q   <= right_len;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for chunk_range_set_queue_core: directed table then random inserts and gets.
// Depends on crsq_pkg and the chunk_range_set_queue_core RTL; self-checking predictor.
`timescale 1ns / 1ps
module tb_top;
	localparam int NRANGE = 16;
	localparam int NRAND = 1330;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic func = 1'b0;
	logic [31:0] first_chunk = '0;
	logic [31:0] chunk_count = '0;
	logic busy, done, chunk_valid, present, table_full;
	logic [31:0] chunk;

	chunk_range_set_queue_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.first_chunk(first_chunk), .chunk_count(chunk_count), .done(done),
		.chunk(chunk), .chunk_valid(chunk_valid), .present(present),
		.table_full(table_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic [31:0] chunk;
		logic        chunk_valid;
		logic        present;
		logic        table_full;
	} outcome_t;

	// predictor state
	logic [31:0] rs[NRANGE];
	logic [31:0] rl[NRANGE];
	int used, cur_idx;
	bit cur_set;
	outcome_t pending_outcomes[$];
	int mismatches = 0;

	function automatic int ser_order(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		if (d == 0) return 0;
		return d[31] ? -1 : 1;
	endfunction

	function automatic logic [31:0] range_end(int i);
		return rs[i] + rl[i];
	endfunction

	function automatic void drop_range(int i);
		if (cur_set) begin
			if (cur_idx == i) begin
				if (i + 1 >= used) begin
					cur_set = 0;
					cur_idx = 0;
				end
			end else if (cur_idx > i) cur_idx--;
		end
		for (int k = i; k + 1 < used; k++) begin
			rs[k] = rs[k+1];
			rl[k] = rl[k+1];
		end
		used--;
	endfunction

	function automatic bit add_range(logic [31:0] first, logic [31:0] cnt);
		logic [31:0] right;
		int p, q;
		if (cnt == 0) return 0;
		right = first + cnt;
		p = used - 1;
		while (p >= 0 && ser_order(right, rs[p]) < 0) p--;
		if (p < 0 || ser_order(first, range_end(p)) > 0) begin
			if (used >= NRANGE) return 1;
			for (int k = used; k > p + 1; k--) begin
				rs[k] = rs[k-1];
				rl[k] = rl[k-1];
			end
			rs[p+1] = first;
			rl[p+1] = cnt;
			used++;
			if (cur_set && cur_idx >= p + 1) cur_idx++;
			return 0;
		end
		if (ser_order(right, range_end(p)) > 0) rl[p] = right - rs[p];
		if (ser_order(first, rs[p]) < 0) begin
			rl[p] = range_end(p) - first;
			rs[p] = first;
			q = p - 1;
			while (q >= 0 && ser_order(range_end(q), rs[p]) >= 0) begin
				rl[p] = range_end(p) - rs[q];
				rs[p] = rs[q];
				drop_range(q);
				p--;
				q = p - 1;
			end
		end
		return 0;
	endfunction

	function automatic outcome_t predict_outcome(logic f, logic [31:0] fc, logic [31:0] cc);
		outcome_t o;
		int c;
		o = '0;
		if (f == crsq_pkg::FuncGet) begin
			if (cur_set && cur_idx >= used) begin
				cur_set = 0;
				cur_idx = 0;
			end
			if (!cur_set && used > 0) begin
				cur_set = 1;
				cur_idx = 0;
			end
			if (cur_set) begin
				c = cur_idx;
				o.chunk = rs[c];
				o.chunk_valid = 1'b1;
				if (rl[c] > 1) begin
					rs[c] = rs[c] + 1;
					rl[c] = rl[c] - 1;
				end else drop_range(c);
			end
		end else o.table_full = add_range(fc, cc);
		o.present = (used > 0 && rl[0] > 0);
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// check each result strobe against the oldest expectation
	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) report_mismatch("unexpected result", chunk, 0);
			else begin
				w = pending_outcomes.pop_front();
				if (chunk !== w.chunk) report_mismatch("chunk", chunk, w.chunk);
				if (chunk_valid !== w.chunk_valid)
					report_mismatch("chunk_valid", chunk_valid, w.chunk_valid);
				if (present !== w.present) report_mismatch("present", present, w.present);
				if (table_full !== w.table_full)
					report_mismatch("table_full", table_full, w.table_full);
			end
		end
	end

	typedef struct {
		logic f;
		logic [31:0] fc;
		logic [31:0] cc;
		bit typed;
		outcome_t want;
	} stim_row_t;

	bit quiet;
	bit window_base;

	// offer one item, hold it until accepted; drop start only while idling
	task automatic send_item(logic f, logic [31:0] fc, logic [31:0] cc, bit typed, outcome_t want);
		outcome_t o;
		while (!quiet && $urandom_range(99) < 14) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		first_chunk <= fc;
		chunk_count <= cc;
		@(posedge clk);
		while (busy) @(posedge clk);
		o = predict_outcome(f, fc, cc);
		if (typed && o !== want) report_mismatch("table row", o.chunk, want.chunk);
		pending_outcomes.push_back(o);
	endtask

	stim_row_t dir_rows[$];

	function automatic stim_row_t row(logic f, logic [31:0] fc, logic [31:0] cc,
			bit typed = 0, outcome_t want = '0);
		stim_row_t r;
		r.f = f; r.fc = fc; r.cc = cc; r.typed = typed; r.want = want;
		return r;
	endfunction

	initial begin
		logic [31:0] fc, cc, base;
		int sel;
		quiet = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// get on empty, zero insert, extremes, touching, wrap, merges, full table
		dir_rows.push_back(row(crsq_pkg::FuncGet, 32'h0, 32'h0, 1, '{0, 0, 0, 0}));
		dir_rows.push_back(row(crsq_pkg::FuncInsert, 32'hFFFF_FFFF, 32'h0, 1, '{0, 0, 0, 0}));
		dir_rows.push_back(row(crsq_pkg::FuncInsert, 32'hFFFF_FFFF, 32'h2, 1, '{0, 0, 1, 0}));
		dir_rows.push_back(row(crsq_pkg::FuncGet, 32'h0, 32'h0, 1,
			'{32'hFFFF_FFFF, 1, 1, 0}));
		dir_rows.push_back(row(crsq_pkg::FuncGet, 32'h0, 32'h0, 1, '{32'h0, 1, 0, 0}));
		dir_rows.push_back(row(crsq_pkg::FuncInsert, 32'd100, 32'd10));
		dir_rows.push_back(row(crsq_pkg::FuncInsert, 32'd110, 32'd5));
		dir_rows.push_back(row(crsq_pkg::FuncInsert, 32'd90, 32'd10));
		dir_rows.push_back(row(crsq_pkg::FuncInsert, 32'd200, 32'd3));
		dir_rows.push_back(row(crsq_pkg::FuncInsert, 32'd80, 32'd125));
		dir_rows.push_back(row(crsq_pkg::FuncInsert, 32'h8000_0000, 32'hFFFF_FFFF));
		dir_rows.push_back(row(crsq_pkg::FuncInsert, 32'h0, 32'h8000_0000));
		for (int i = 0; i < 17; i++)
			dir_rows.push_back(row(crsq_pkg::FuncInsert, 32'd1000 + 4 * i, 32'd1));
		foreach (dir_rows[i])
			send_item(dir_rows[i].f, dir_rows[i].fc, dir_rows[i].cc, dir_rows[i].typed,
				dir_rows[i].want);
		for (int n = 0; n < NRAND; n++) begin
			quiet = (n >= 400 && n < 550);
			// every 300 items move the small window to one of two bases, one just below the wrap
			if (n % 300 == 0) window_base = $urandom_range(1);
			base = window_base ? 32'hFFFF_FF00 : 32'h0000_0100;
			sel = $urandom_range(99);
			if (sel < 45) begin
				fc = base + $urandom_range(255);
				cc = $urandom_range(12);
				send_item(crsq_pkg::FuncInsert, fc, cc, 0, '0);
			end else if (sel < 52) begin
				send_item(crsq_pkg::FuncInsert, $urandom(), $urandom(), 0, '0);
			end else if (sel < 56) begin
				send_item(crsq_pkg::FuncInsert, $urandom(), $urandom_range(40), 0, '0);
			end else send_item(crsq_pkg::FuncGet, $urandom(), $urandom(), 0, '0);
		end
		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+src
src/crsq_pkg.sv
src/crsq_cell.sv
src/chunk_range_set_queue_core.sv
test/tb_top.sv
